FILE: rtl/point_in_polygon_ray_cast_defines.svh
// assertion macros shared by the point-in-polygon checker
`ifndef POINT_IN_POLYGON_RAY_CAST_DEFINES_SVH
`define POINT_IN_POLYGON_RAY_CAST_DEFINES_SVH

// same-cycle implication, quiet during reset
`define PIPR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define PIPR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also runs while reset is applied
`define PIPR_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/pipr_pkg.sv
// shared constants for the point-in-polygon ray-cast block
package pipr_pkg;

  // default sizes
  localparam int MAX_VERTICES_DEF = 16;
  localparam int COORD_WIDTH_DEF  = 16;

  // fewer vertices than this never form a polygon
  localparam int MIN_VERTICES = 3;

  // fixed field widths
  localparam int CNT_W     = 5;
  localparam int IDX_W     = 4;
  localparam int CFG_IDX_W = 1;
  localparam int OUT_DW    = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAR_X        = 1'b1;

  // register reset values
  localparam int FAR_X_RESET = 10000;

  // item kinds
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // items held between front and back
  localparam int QUEUE_DEPTH = 2;

endpackage

FILE: rtl/pipr_ram.sv
// generic single-write, single-read ram with registered read data
module pipr_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem_r [DEPTH];
  logic [W-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/pipr_front.sv
// front end: accepts items, drops writes to missing slots, packs queue entries
module pipr_front #(
  parameter int MAX_VERTICES = pipr_pkg::MAX_VERTICES_DEF,
  parameter int COORD_WIDTH  = pipr_pkg::COORD_WIDTH_DEF,
  localparam int AW    = $clog2(MAX_VERTICES),
  localparam int QW    = 1 + AW + 2 * COORD_WIDTH,
  localparam int IN_DW = ((pipr_pkg::IDX_W + 2 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_DW-1:0] in_tdata,
  input  logic             in_tuser,
  output logic             q_valid,
  input  logic             q_ready,
  output logic [QW-1:0]    q_data
);

  import pipr_pkg::*;

  logic [IDX_W-1:0]       idx;
  logic [COORD_WIDTH-1:0] cx;
  logic [COORD_WIDTH-1:0] cy;
  logic                   slot_ok;
  logic                   is_query;

  // unpack the item
  assign idx = in_tdata[IDX_W-1:0];
  assign cx  = in_tdata[IDX_W+COORD_WIDTH-1:IDX_W];
  assign cy  = in_tdata[IDX_W+2*COORD_WIDTH-1:IDX_W+COORD_WIDTH];

  // classify: queries always go on, writes only to existing slots
  assign is_query = (in_tuser == CMD_QUERY);
  assign slot_ok  = int'(idx) < MAX_VERTICES;

  // an ignored write is still taken, it just never reaches the queue
  assign in_tready = q_ready;
  assign q_valid   = in_tvalid && (is_query || slot_ok);
  assign q_data    = {cy, cx, AW'(idx), in_tuser};

endmodule

FILE: rtl/pipr_queue.sv
// short fifo between front and back
module pipr_queue #(
  parameter int W     = 8,
  parameter int DEPTH = pipr_pkg::QUEUE_DEPTH,
  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNTW = $clog2(DEPTH + 1)
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  logic [W-1:0]    mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0] count_r, count_nxt;
  logic            push;
  logic            pop;

  assign push_ready = (count_r != CNTW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNTW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/pipr_back.sv
// back end: vertex writes and the edge walk with a pipelined crossing test
module pipr_back #(
  parameter int MAX_VERTICES = pipr_pkg::MAX_VERTICES_DEF,
  parameter int COORD_WIDTH  = pipr_pkg::COORD_WIDTH_DEF,
  localparam int AW = $clog2(MAX_VERTICES),
  localparam int QW = 1 + AW + 2 * COORD_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  logic [QW-1:0]                 q_data,
  input  logic [pipr_pkg::CNT_W-1:0]    vertex_count,
  input  logic signed [COORD_WIDTH-1:0] far_x,
  output logic                          ram_we,
  output logic [AW-1:0]                 ram_waddr,
  output logic [2*COORD_WIDTH-1:0]      ram_wdata,
  output logic [AW-1:0]                 ram_raddr,
  input  logic [2*COORD_WIDTH-1:0]      ram_rdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [pipr_pkg::OUT_DW-1:0]   out_tdata
);

  import pipr_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int DW   = CW + 1;
  localparam int PW   = 2 * DW;
  localparam int SW   = PW + 1;
  localparam int NW   = $clog2(MAX_VERTICES + 1);
  localparam int CNTW = (NW > CNT_W) ? NW : CNT_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_ISSUE  = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_RESULT = 2'd3;

  localparam logic [1:0] ORI_COL = 2'd0;
  localparam logic [1:0] ORI_CW  = 2'd1;
  localparam logic [1:0] ORI_CCW = 2'd2;

  // queue entry fields
  logic                 q_kind;
  logic [AW-1:0]        q_addr;
  logic signed [CW-1:0] q_x, q_y;
  logic [NW-1:0]        n_sat;
  logic                 q_query;

  assign q_kind  = q_data[0];
  assign q_addr  = q_data[AW:1];
  assign q_x     = q_data[AW+CW:AW+1];
  assign q_y     = q_data[AW+2*CW:AW+CW+1];
  assign q_query = q_valid && (q_kind == CMD_QUERY);

  // vertex count clipped to the table size
  always_comb begin
    if (CNTW'(vertex_count) > CNTW'(MAX_VERTICES)) begin
      n_sat = NW'(MAX_VERTICES);
    end else begin
      n_sat = NW'(CNTW'(vertex_count));
    end
  end

  // control state
  logic [1:0]           state_r, state_nxt;
  logic [NW-1:0]        k_r, k_nxt;
  logic [NW-1:0]        n_r;
  logic signed [CW-1:0] px_r, py_r;
  logic                 res_r, res_nxt;
  logic                 out_vld_r, out_vld_nxt;
  logic                 out_res_r;
  logic                 out_load;
  logic                 issue;
  logic                 start;

  // edge pipeline
  logic                 s0_vld_r, s0_first_r, s0_close_r;
  logic signed [CW-1:0] rd_x, rd_y, cur_x, cur_y;
  logic signed [CW-1:0] v0_x_r, v0_y_r, prev_x_r, prev_y_r;
  logic                 s1_vld_r, s1_last_r;
  logic signed [CW-1:0] s1_ax_r, s1_ay_r, s1_bx_r, s1_by_r;
  logic                 s2_vld_r, s2_last_r;
  logic signed [DW-1:0] s2_dy_r, s2_dx_r, s2_ex1_r, s2_ex2_r, s2_ey_r;
  logic [1:0]           s2_o3_r, s2_o4_r;
  logic                 s2_box_a_r, s2_box_b_r, s2_box_c_r, s2_box_d_r;
  logic                 s3_vld_r, s3_last_r;
  logic signed [PW-1:0] s3_m1_r, s3_m2_r, s3_m3_r;
  logic [1:0]           s3_o3_r, s3_o4_r;
  logic                 s3_box_a_r, s3_box_b_r, s3_box_c_r, s3_box_d_r;

  // stage 1 combinational terms
  logic [1:0] o3, o4;
  logic       box_a, box_b, box_c, box_d;

  // stage 3 decision
  logic signed [SW-1:0] d1, d2;
  logic [1:0]           o1, o2;
  logic                 meet, hit_new;
  logic                 par_r, par_nxt, hit_r, hit_nxt, hv_r, hv_nxt;
  logic                 final_res;

  assign q_ready   = (state_r == ST_IDLE);
  assign issue     = (state_r == ST_ISSUE);
  assign start     = q_ready && q_query;
  assign ram_we    = q_ready && q_valid && (q_kind == CMD_WRITE);
  assign ram_waddr = q_addr;
  assign ram_wdata = {q_y, q_x};
  assign ram_raddr = k_r[AW-1:0];

  // sequencer
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    res_nxt   = res_r;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_query) begin
          k_nxt = '0;
          if (n_sat < NW'(MIN_VERTICES)) begin
            res_nxt   = 1'b0;
            state_nxt = ST_RESULT;
          end else begin
            state_nxt = ST_ISSUE;
          end
        end
      end
      ST_ISSUE: begin
        k_nxt = k_r + NW'(1);
        if (k_r == n_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (s3_vld_r && s3_last_r) begin
          res_nxt   = final_res;
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_vld_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // output register
  always_comb begin
    if (out_load) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
      s0_vld_r  <= 1'b0;
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
      s0_vld_r  <= issue;
      s1_vld_r  <= s0_vld_r && !s0_first_r;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
    end
  end

  // query context and result
  always_ff @(posedge clk) begin
    k_r   <= k_nxt;
    res_r <= res_nxt;
    if (start) begin
      n_r  <= n_sat;
      px_r <= q_x;
      py_r <= q_y;
    end
    if (out_load) begin
      out_res_r <= res_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {(OUT_DW - 1)'(0), out_res_r};

  // stage 0: read tag, then pair the vertex with the one before it
  assign rd_x  = ram_rdata[CW-1:0];
  assign rd_y  = ram_rdata[2*CW-1:CW];
  assign cur_x = s0_close_r ? v0_x_r : rd_x;
  assign cur_y = s0_close_r ? v0_y_r : rd_y;

  always_ff @(posedge clk) begin
    s0_first_r <= (k_r == '0);
    s0_close_r <= (k_r == n_r);
    if (s0_vld_r && s0_first_r) begin
      v0_x_r <= rd_x;
      v0_y_r <= rd_y;
    end
    if (s0_vld_r) begin
      prev_x_r <= cur_x;
      prev_y_r <= cur_y;
    end
    s1_last_r <= s0_close_r;
    s1_ax_r   <= prev_x_r;
    s1_ay_r   <= prev_y_r;
    s1_bx_r   <= cur_x;
    s1_by_r   <= cur_y;
  end

  // stage 1: differences, ray-side orientations and bounding boxes
  always_comb begin
    // the ray is horizontal, so its orientations reduce to sign tests
    if ((far_x == px_r) || (s1_ay_r == py_r)) begin
      o3 = ORI_COL;
    end else begin
      o3 = ((far_x > px_r) != (s1_ay_r > py_r)) ? ORI_CW : ORI_CCW;
    end
    if ((far_x == px_r) || (s1_by_r == py_r)) begin
      o4 = ORI_COL;
    end else begin
      o4 = ((far_x > px_r) != (s1_by_r > py_r)) ? ORI_CW : ORI_CCW;
    end
    // point inside the edge's box
    box_a = ((px_r <= s1_ax_r) || (px_r <= s1_bx_r)) &&
            ((px_r >= s1_ax_r) || (px_r >= s1_bx_r)) &&
            ((py_r <= s1_ay_r) || (py_r <= s1_by_r)) &&
            ((py_r >= s1_ay_r) || (py_r >= s1_by_r));
    // far end inside the edge's box
    box_b = ((far_x <= s1_ax_r) || (far_x <= s1_bx_r)) &&
            ((far_x >= s1_ax_r) || (far_x >= s1_bx_r)) &&
            ((py_r <= s1_ay_r) || (py_r <= s1_by_r)) &&
            ((py_r >= s1_ay_r) || (py_r >= s1_by_r));
    // edge ends inside the ray's box
    box_c = ((s1_ax_r <= px_r) || (s1_ax_r <= far_x)) &&
            ((s1_ax_r >= px_r) || (s1_ax_r >= far_x)) && (s1_ay_r == py_r);
    box_d = ((s1_bx_r <= px_r) || (s1_bx_r <= far_x)) &&
            ((s1_bx_r >= px_r) || (s1_bx_r >= far_x)) && (s1_by_r == py_r);
  end

  always_ff @(posedge clk) begin
    s2_last_r  <= s1_last_r;
    s2_dy_r    <= DW'(s1_by_r) - DW'(s1_ay_r);
    s2_dx_r    <= DW'(s1_bx_r) - DW'(s1_ax_r);
    s2_ex1_r   <= DW'(px_r) - DW'(s1_bx_r);
    s2_ex2_r   <= DW'(far_x) - DW'(s1_bx_r);
    s2_ey_r    <= DW'(py_r) - DW'(s1_by_r);
    s2_o3_r    <= o3;
    s2_o4_r    <= o4;
    s2_box_a_r <= box_a;
    s2_box_b_r <= box_b;
    s2_box_c_r <= box_c;
    s2_box_d_r <= box_d;
  end

  // stage 2: exact cross products
  always_ff @(posedge clk) begin
    s3_last_r  <= s2_last_r;
    s3_m1_r    <= PW'(s2_dy_r) * PW'(s2_ex1_r);
    s3_m2_r    <= PW'(s2_dx_r) * PW'(s2_ey_r);
    s3_m3_r    <= PW'(s2_dy_r) * PW'(s2_ex2_r);
    s3_o3_r    <= s2_o3_r;
    s3_o4_r    <= s2_o4_r;
    s3_box_a_r <= s2_box_a_r;
    s3_box_b_r <= s2_box_b_r;
    s3_box_c_r <= s2_box_c_r;
    s3_box_d_r <= s2_box_d_r;
  end

  // stage 3: edge-side orientations, intersection and running answer
  always_comb begin
    d1 = SW'(s3_m1_r) - SW'(s3_m2_r);
    d2 = SW'(s3_m3_r) - SW'(s3_m2_r);
    o1 = (d1 == '0) ? ORI_COL : (d1[SW-1] ? ORI_CCW : ORI_CW);
    o2 = (d2 == '0) ? ORI_COL : (d2[SW-1] ? ORI_CCW : ORI_CW);
    meet = ((o1 != o2) && (s3_o3_r != s3_o4_r)) ||
           ((o1 == ORI_COL) && s3_box_a_r) ||
           ((o2 == ORI_COL) && s3_box_b_r) ||
           ((s3_o3_r == ORI_COL) && s3_box_c_r) ||
           ((s3_o4_r == ORI_COL) && s3_box_d_r);
    // point collinear with a met edge settles the answer
    hit_new   = meet && (o1 == ORI_COL);
    hit_nxt   = hit_r || hit_new;
    hv_nxt    = hit_r ? hv_r : s3_box_a_r;
    par_nxt   = par_r ^ (meet && !hit_new);
    final_res = hit_nxt ? hv_nxt : par_nxt;
  end

  always_ff @(posedge clk) begin
    if (start) begin
      par_r <= 1'b0;
      hit_r <= 1'b0;
      hv_r  <= 1'b0;
    end else if (s3_vld_r) begin
      par_r <= par_nxt;
      hit_r <= hit_nxt;
      hv_r  <= hv_nxt;
    end
  end

endmodule

FILE: rtl/point_in_polygon_ray_cast.sv
// top level of the point-in-polygon ray-cast block
//
//   channel  dir  handshake              payload
//   in_      in   in_tvalid/in_tready    in_tuser = cmd, in_tdata = index, x, y
//   out_     out  out_tvalid/out_tready  out_tdata = inside_res
//   cfg_     in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// a vertex write is taken by the back end while it is idle; a query over n vertices
// makes n + 1 reads through the single vertex ram read port, one edge
// a cycle, then passes the 4-stage crossing pipeline and the output load.
// a query with fewer than three vertices skips the edge walk and answers outside.
// reset is synchronous; the vertex table is not cleared and needs no sweep.
// a two-item queue and the output register let either side stall on its own.
module point_in_polygon_ray_cast #(
  parameter int MAX_VERTICES = pipr_pkg::MAX_VERTICES_DEF,
  parameter int COORD_WIDTH  = pipr_pkg::COORD_WIDTH_DEF,
  localparam int IN_DW = ((pipr_pkg::IDX_W + 2 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [IN_DW-1:0]                 in_tdata,   // vertex_index, coord_x, coord_y
  input  logic                             in_tuser,   // cmd
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [pipr_pkg::OUT_DW-1:0]      out_tdata,  // inside_res
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pipr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [COORD_WIDTH-1:0]           cfg_data
);

  import pipr_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int QW = 1 + AW + 2 * COORD_WIDTH;

  logic [CNT_W-1:0]              vcount_r;
  logic signed [COORD_WIDTH-1:0] far_x_r;

  logic          f_valid, f_ready;
  logic [QW-1:0] f_data;
  logic          b_valid, b_ready;
  logic [QW-1:0] b_data;

  logic                     ram_we;
  logic [AW-1:0]            ram_waddr, ram_raddr;
  logic [2*COORD_WIDTH-1:0] ram_wdata, ram_rdata;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= '0;
      far_x_r  <= COORD_WIDTH'(FAR_X_RESET);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_VERTEX_COUNT: vcount_r <= cfg_data[CNT_W-1:0];
        CFG_FAR_X:        far_x_r  <= cfg_data;
        default:          ;
      endcase
    end
  end

  pipr_front #(
    .MAX_VERTICES(MAX_VERTICES),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .q_valid  (f_valid),
    .q_ready  (f_ready),
    .q_data   (f_data)
  );

  pipr_queue #(
    .W    (QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(f_valid),
    .push_ready(f_ready),
    .push_data (f_data),
    .pop_valid (b_valid),
    .pop_ready (b_ready),
    .pop_data  (b_data)
  );

  pipr_ram #(
    .W    (2 * COORD_WIDTH),
    .DEPTH(MAX_VERTICES)
  ) u_vertex_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  pipr_back #(
    .MAX_VERTICES(MAX_VERTICES),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (b_valid),
    .q_ready     (b_ready),
    .q_data      (b_data),
    .vertex_count(vcount_r),
    .far_x       (far_x_r),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule

FILE: rtl/pipr_checker.sv
// port-level checks for the point-in-polygon block, bound to the top level
`include "point_in_polygon_ray_cast_defines.svh"

module pipr_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [pipr_pkg::OUT_DW-1:0] out_tdata
);

  import pipr_pkg::*;

  // a stalled result stays offered
  `PIPR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid, "result item dropped while stalled")

  // a stalled result keeps its value
  `PIPR_ASSERT_NEXT(a_out_stable, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata), "result item changed while stalled")

  // only the answer bit may be set
  `PIPR_ASSERT_IMPL(a_out_pad, clk, rst_n, out_tvalid, out_tdata[OUT_DW-1:1] == '0, "padding bits set in result item")

  // reset empties the queue and the output register
  `PIPR_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n, !out_tvalid && in_tready, "block not idle after reset")

endmodule

bind point_in_polygon_ray_cast pipr_checker u_pipr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

FILE: verif/point_in_polygon_ray_cast_tb.sv
// self-checking testbench for the point-in-polygon ray-cast block
module point_in_polygon_ray_cast_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pipr_pkg::*;

  localparam int MAX_V         = MAX_VERTICES_DEF;
  localparam int COORD_W       = COORD_WIDTH_DEF;
  localparam int IN_DW         = ((IDX_W + 2 * COORD_W + 7) / 8) * 8;
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD     = 500;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef enum int {COLLINEAR, CLOCKWISE, COUNTER_CLOCKWISE} turn_t;
  typedef enum int {SPREAD_TIGHT, SPREAD_FULL, SPREAD_MID} spread_t;
  typedef enum int {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic                   cmd;
    logic [IDX_W-1:0]       idx;
    coord_t                 x;
    coord_t                 y;
    bit                     typed;
    bit                     typed_inside;
    logic [CFG_IDX_W-1:0]   reg_sel;
    logic [COORD_W-1:0]     reg_val;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DW-1:0]      in_tdata;   // vertex_index, coord_x, coord_y
  logic                  in_tuser;   // cmd
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DW-1:0]     out_tdata;  // inside_res
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [COORD_W-1:0]    cfg_data;

  // mirror of the block's vertex table and registers
  coord_t            vx_mem [MAX_V];
  coord_t            vy_mem [MAX_V];
  logic [CNT_W-1:0]  vert_count;
  coord_t            ray_far_x;

  bit        inside_q [$];
  stim_row_t directed_rows [$];
  int        err_count;
  int        results_seen;
  int        send_idle_pct;
  int        recv_idle_pct;

  point_in_polygon_ray_cast uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  // turn direction of p -> q -> r, exact in 64 bits
  function automatic turn_t turn_of(longint px, longint py, longint qx, longint qy,
                                    longint rx, longint ry);
    longint d;
    d = (qy - py) * (rx - qx) - (qx - px) * (ry - qy);
    if (d == 0) return COLLINEAR;
    return (d < 0) ? COUNTER_CLOCKWISE : CLOCKWISE;
  endfunction

  // q inside the bounding box of p and r
  function automatic bit in_box(longint px, longint py, longint qx, longint qy,
                                longint rx, longint ry);
    return qx <= ((px > rx) ? px : rx) && qx >= ((px < rx) ? px : rx) &&
           qy <= ((py > ry) ? py : ry) && qy >= ((py < ry) ? py : ry);
  endfunction

  // segment a-b against segment c-d with collinear cases
  function automatic bit segments_cross(longint ax, longint ay, longint bx, longint by,
                                        longint cx, longint cy, longint dx, longint dy);
    turn_t t1, t2, t3, t4;
    t1 = turn_of(ax, ay, bx, by, cx, cy);
    t2 = turn_of(ax, ay, bx, by, dx, dy);
    t3 = turn_of(cx, cy, dx, dy, ax, ay);
    t4 = turn_of(cx, cy, dx, dy, bx, by);
    if (t1 != t2 && t3 != t4) return 1'b1;
    if (t1 == COLLINEAR && in_box(ax, ay, cx, cy, bx, by)) return 1'b1;
    if (t2 == COLLINEAR && in_box(ax, ay, dx, dy, bx, by)) return 1'b1;
    if (t3 == COLLINEAR && in_box(cx, cy, ax, ay, dx, dy)) return 1'b1;
    if (t4 == COLLINEAR && in_box(cx, cy, bx, by, dx, dy)) return 1'b1;
    return 1'b0;
  endfunction

  // crossing-number answer for one query point
  function automatic bit inside_polygon(coord_t px, coord_t py);
    int     n, i, j, crossings;
    longint ax, ay, bx, by, qx, qy, fx;
    n = (vert_count > MAX_V) ? MAX_V : int'(vert_count);
    if (n < MIN_VERTICES) return 1'b0;
    qx = px;
    qy = py;
    fx = ray_far_x;
    crossings = 0;
    for (i = 0; i < n; i++) begin
      j = (i + 1 == n) ? 0 : i + 1;
      ax = vx_mem[i];
      ay = vy_mem[i];
      bx = vx_mem[j];
      by = vy_mem[j];
      if (segments_cross(ax, ay, bx, by, qx, qy, fx, qy)) begin
        // point on the edge line: answer is whether it sits on the edge
        if (turn_of(ax, ay, qx, qy, bx, by) == COLLINEAR) return in_box(ax, ay, qx, qy, bx, by);
        crossings++;
      end
    end
    return crossings[0];
  endfunction

  function automatic coord_t rand_coord(spread_t spread);
    case (spread)
      SPREAD_TIGHT: return coord_t'(int'($urandom_range(16)) - 8);
      SPREAD_FULL:  return coord_t'($urandom);
      default:      return coord_t'(int'($urandom_range(2000)) - 1000);
    endcase
  endfunction

  // offer one item, update the mirror and queue the answer on acceptance
  task automatic send_item(input logic cmd, input logic [IDX_W-1:0] idx, input coord_t x,
                           input coord_t y, input bit typed, input bit typed_inside);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {{(IN_DW - IDX_W - 2 * COORD_W){1'b0}}, y, x, idx};
    do @(posedge clk); while (!in_tready);
    if (cmd == CMD_WRITE) begin
      vx_mem[idx] = x;
      vy_mem[idx] = y;
    end else begin
      inside_q.push_back(typed ? typed_inside : inside_polygon(x, y));
    end
  endtask

  // stop offering and wait for every queued answer
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (inside_q.size() != 0);
  endtask

  // register writes, only once the block has gone idle
  task automatic program_regs(input bit do_cnt, input logic [CNT_W-1:0] cnt,
                              input bit do_far, input coord_t far);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (do_cnt) begin
      cfg_valid <= 1'b1;
      cfg_index <= CFG_VERTEX_COUNT;
      cfg_data  <= {{(COORD_W - CNT_W){1'b0}}, cnt};
      do @(posedge clk); while (!cfg_ready);
      vert_count = cnt;
    end
    if (do_far) begin
      cfg_valid <= 1'b1;
      cfg_index <= CFG_FAR_X;
      cfg_data  <= far;
      do @(posedge clk); while (!cfg_ready);
      ray_far_x = far;
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic add_item(input logic cmd, input int idx, input int x, input int y,
                          input bit typed, input bit typed_inside);
    stim_row_t r;
    r = '{kind: ROW_ITEM, cmd: cmd, idx: IDX_W'(idx), x: coord_t'(x), y: coord_t'(y),
          typed: typed, typed_inside: typed_inside, reg_sel: CFG_VERTEX_COUNT, reg_val: '0};
    directed_rows.push_back(r);
  endtask

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] sel, input int val);
    stim_row_t r;
    r = '{kind: ROW_CFG, cmd: CMD_WRITE, idx: '0, x: '0, y: '0, typed: 1'b0,
          typed_inside: 1'b0, reg_sel: sel, reg_val: COORD_W'(val)};
    directed_rows.push_back(r);
  endtask

  // one setting: fresh polygons, each followed by a burst of queries
  task automatic run_phase(input logic [CNT_W-1:0] cnt, input coord_t far, input int s_pct,
                           input int r_pct, input int n_items);
    int      sent, nv, k, a, b, xmin, xmax, ymin, ymax;
    bit      paused;
    spread_t spread;
    coord_t  qx, qy;
    program_regs(1'b1, cnt, 1'b1, far);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    sent = 0;
    paused = 1'b0;
    nv = (cnt > MAX_V) ? MAX_V : int'(cnt);
    if (nv < MIN_VERTICES) nv = MIN_VERTICES;
    while (sent < n_items) begin
      spread = spread_t'($urandom_range(2));
      for (k = 0; k < nv; k++) begin
        send_item(CMD_WRITE, IDX_W'(k), rand_coord(spread), rand_coord(spread), 1'b0, 1'b0);
        sent++;
      end
      xmin = vx_mem[0];
      xmax = vx_mem[0];
      ymin = vy_mem[0];
      ymax = vy_mem[0];
      for (k = 1; k < nv; k++) begin
        if (vx_mem[k] < xmin) xmin = vx_mem[k];
        if (vx_mem[k] > xmax) xmax = vx_mem[k];
        if (vy_mem[k] < ymin) ymin = vy_mem[k];
        if (vy_mem[k] > ymax) ymax = vy_mem[k];
      end
      repeat ($urandom_range(6, 20)) begin
        a = $urandom_range(nv - 1);
        b = (a + 1) % nv;
        qx = coord_t'(xmin - 2 + int'($urandom_range(xmax - xmin + 4)));
        qy = coord_t'(ymin - 2 + int'($urandom_range(ymax - ymin + 4)));
        case ($urandom_range(9))
          0, 1: begin
            // exactly on a vertex
            qx = vx_mem[a];
            qy = vy_mem[a];
          end
          2: begin
            // on or beside an edge
            qx = coord_t'((int'(vx_mem[a]) + int'(vx_mem[b])) >>> 1);
            qy = coord_t'((int'(vy_mem[a]) + int'(vy_mem[b])) >>> 1);
          end
          3: qy = vy_mem[a];
          4, 5: begin
            qx = coord_t'($urandom);
            qy = coord_t'($urandom);
          end
          default: ;
        endcase
        send_item(CMD_QUERY, IDX_W'($urandom), qx, qy, 1'b0, 1'b0);
        sent++;
      end
      // stray vertex write
      if ($urandom_range(3) == 0) begin
        send_item(CMD_WRITE, IDX_W'($urandom), rand_coord(SPREAD_FULL),
                  rand_coord(SPREAD_FULL), 1'b0, 1'b0);
        sent++;
      end
      if (!paused && sent >= n_items / 2) begin
        drain_results();
        paused = 1'b1;
      end
    end
  endtask

  // result side: random ready, one long hold-off, compare with oldest answer
  initial begin
    int  hold_left;
    bit  held;
    bit  want;
    hold_left = 0;
    held = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (inside_q.size() == 0) begin
          $error("inside_res: result with no query waiting, actual %0b", out_tdata[0]);
          err_count++;
        end else begin
          want = inside_q.pop_front();
          if (out_tdata[0] !== want) begin
            $error("inside_res mismatch: expected %0b, actual %0b", want, out_tdata[0]);
            err_count++;
          end
        end
        results_seen++;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (!held && results_seen == 40) begin
        held = 1'b1;
        hold_left = LONG_HOLD - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // run limit
  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // reset, directed table, then random phases
  initial begin
    int k;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = CMD_WRITE;
    cfg_valid = 1'b0;
    cfg_index = CFG_VERTEX_COUNT;
    cfg_data = '0;
    err_count = 0;
    results_seen = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    vert_count = '0;
    ray_far_x = coord_t'(FAR_X_RESET);
    for (k = 0; k < MAX_V; k++) begin
      vx_mem[k] = '0;
      vy_mem[k] = '0;
    end

    // after reset: no vertices, everything outside
    add_item(CMD_QUERY, 0, 0, 0, 1'b1, 1'b0);
    add_item(CMD_QUERY, 5, -32768, -32768, 1'b1, 1'b0);
    add_item(CMD_QUERY, 15, 32767, 32767, 1'b1, 1'b0);
    // square around the origin
    add_item(CMD_WRITE, 0, -100, -100, 1'b0, 1'b0);
    add_item(CMD_WRITE, 1, 100, -100, 1'b0, 1'b0);
    add_item(CMD_WRITE, 2, 100, 100, 1'b0, 1'b0);
    add_item(CMD_WRITE, 3, -100, 100, 1'b0, 1'b0);
    // two vertices are not a polygon
    add_cfg(CFG_VERTEX_COUNT, 2);
    add_item(CMD_QUERY, 0, 0, 0, 1'b1, 1'b0);
    add_cfg(CFG_VERTEX_COUNT, 4);
    add_item(CMD_QUERY, 0, 0, 0, 1'b0, 1'b0);
    add_item(CMD_QUERY, 0, 100, 0, 1'b0, 1'b0);
    add_item(CMD_QUERY, 0, -100, 100, 1'b0, 1'b0);
    add_item(CMD_QUERY, 0, 200, 0, 1'b0, 1'b0);
    add_item(CMD_QUERY, 0, -200, 100, 1'b0, 1'b0);
    add_item(CMD_QUERY, 0, -200, 0, 1'b0, 1'b0);
    // far end left of the point, then equal to it
    add_cfg(CFG_FAR_X, -32768);
    add_item(CMD_QUERY, 0, 0, 0, 1'b0, 1'b0);
    add_item(CMD_QUERY, 0, -32768, 50, 1'b0, 1'b0);
    // triangle spanning the whole coordinate range
    add_item(CMD_WRITE, 0, -32768, -32768, 1'b0, 1'b0);
    add_item(CMD_WRITE, 1, 32767, -32768, 1'b0, 1'b0);
    add_item(CMD_WRITE, 2, 0, 32767, 1'b0, 1'b0);
    add_cfg(CFG_VERTEX_COUNT, 3);
    add_cfg(CFG_FAR_X, 32767);
    add_item(CMD_QUERY, 0, -32768, -32768, 1'b0, 1'b0);
    add_item(CMD_QUERY, 0, 32767, 32767, 1'b0, 1'b0);
    add_item(CMD_QUERY, 0, 0, 0, 1'b0, 1'b0);
    add_item(CMD_QUERY, 0, 32767, -32768, 1'b0, 1'b0);
    add_item(CMD_QUERY, 0, -1, 32767, 1'b0, 1'b0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[ri]) begin
      if (directed_rows[ri].kind == ROW_CFG) begin
        if (directed_rows[ri].reg_sel == CFG_VERTEX_COUNT)
          program_regs(1'b1, directed_rows[ri].reg_val[CNT_W-1:0], 1'b0, '0);
        else
          program_regs(1'b0, '0, 1'b1, coord_t'(directed_rows[ri].reg_val));
      end else begin
        send_item(directed_rows[ri].cmd, directed_rows[ri].idx, directed_rows[ri].x,
                  directed_rows[ri].y, directed_rows[ri].typed,
                  directed_rows[ri].typed_inside);
      end
    end

    // every slot written before any wider polygon is queried
    for (k = 0; k < MAX_V; k++)
      send_item(CMD_WRITE, IDX_W'(k), rand_coord(SPREAD_FULL), rand_coord(SPREAD_FULL),
                1'b0, 1'b0);

    // sender idles lightly, receiver heavily; count above table size first
    run_phase(5'd31, coord_t'(32767), 16, 55, 125);
    run_phase(5'd3, coord_t'(-32768), 16, 55, 125);
    run_phase(CNT_W'($urandom_range(4, 16)), coord_t'($urandom), 16, 55, 125);
    // sender idles heavily, receiver lightly
    run_phase(5'd16, coord_t'(FAR_X_RESET), 55, 16, 125);
    run_phase(5'd0, coord_t'($urandom), 55, 16, 60);
    run_phase(CNT_W'($urandom_range(3, 16)), coord_t'(0), 55, 16, 125);
    // no idling on either side
    run_phase(5'd2, coord_t'($urandom), 0, 0, 60);
    run_phase(CNT_W'($urandom_range(3, 8)), coord_t'(32767), 0, 0, 150);
    run_phase(5'd16, coord_t'(-32768), 0, 0, 150);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (inside_q.size() != 0) begin
      $error("inside_res: %0d expected results never arrived", inside_q.size());
      err_count++;
    end
    if (err_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/pipr_pkg.sv
rtl/pipr_ram.sv
rtl/pipr_front.sv
rtl/pipr_queue.sv
rtl/pipr_back.sv
rtl/point_in_polygon_ray_cast.sv
rtl/pipr_checker.sv
verif/point_in_polygon_ray_cast_tb.sv
